// File: rtl/core/drem_pkg.sv
package drem_pkg;

    localparam int unsigned NUM_BUTTONS = 3;

    localparam logic [1:0] BTN_GENERAL = 2'd0;
    localparam logic [1:0] BTN_PART    = 2'd1;
    localparam logic [1:0] BTN_DATA    = 2'd2;

    localparam logic [1:0] REG_DEBOUNCE_LIMIT = 2'd0;
    localparam logic [1:0] REG_GENERAL_MAX    = 2'd1;
    localparam logic [1:0] REG_PART_MAX       = 2'd2;
    localparam logic [1:0] REG_STEP_MAX       = 2'd3;

    localparam logic [7:0] DEBOUNCE_LIMIT_RST = 8'd50;
    localparam logic [7:0] GENERAL_MAX_RST    = 8'd6;
    localparam logic [7:0] PART_MAX_RST       = 8'd8;
    localparam logic [7:0] STEP_MAX_RST       = 8'd4;

    localparam logic [7:0] TIMER_MAX = 8'd255;

    typedef enum logic [2:0] {
        SRC_GENERAL = 3'd0,
        SRC_PATTERN = 3'd1,
        SRC_PART    = 3'd2,
        SRC_STEP    = 3'd3,
        SRC_DATA    = 3'd4
    } source_t;

    typedef struct packed {
        logic data_dt;
        logic data_clk;
        logic part_dt;
        logic part_clk;
        logic general_dt;
        logic general_clk;
        logic data_button;
        logic part_button;
        logic general_button;
        logic ms_tick;
    } sample_t;

    typedef struct packed {
        logic       part_led;
        logic       general_led;
        logic [2:0] active_source;
        logic [7:0] step_index;
        logic [7:0] part_index;
        logic       turn_direction;
        logic [7:0] parameter_index;
    } result_t;

    function automatic logic [7:0] step_clamp(
        input logic [7:0] idx,
        input logic       clk,
        input logic       dt,
        input logic       edge_seen,
        input logic [7:0] max_idx
    );
        logic [7:0] v;
        v = idx;
        if (edge_seen) begin
            if (dt != clk) begin
                if (v != 8'd0) v = v - 8'd1;
            end else begin
                if (v != 8'hFF) v = v + 8'd1;
            end
        end
        if (v > max_idx) v = max_idx;
        return v;
    endfunction

endpackage

// File: rtl/core/debounced_rotary_encoder_menu.sv
// Debounced rotary encoder menu.
// Input stream: one word per sample of three buttons, three encoders and a
// millisecond tick flag. Output stream: one word per sample with the menu
// indices, the pattern turn direction, the last touched control and two LEDs.
// Configuration: plain write port (cfg_wen, cfg_index, cfg_wdata) for the
// debounce limit and the three index maxima; write it only while idle.
// Pipeline: an input register feeds the update logic, which loads the output
// register and the menu state in the same cycle. Each sample passes the input
// register, then the output register. Throughput, set by the single update
// stage, is one sample per cycle while the receiver takes each output word.
// When the receiver stalls, the output register holds its word and the input
// register still takes one more sample; after that s_axis_tready drops until
// the output word is taken.
// Reset clears both pipeline valids, puts both buttons in general/part mode,
// marks all buttons released, zeroes timers, indices and the source, and
// loads the default register values.
module debounced_rotary_encoder_menu
    import drem_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // ms_tick, general_button, part_button, data_button, general_clk,
    // general_dt, part_clk, part_dt, data_clk, data_dt, zero fill
    input  logic [15:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // parameter_index[7:0], turn_direction, part_index[7:0], step_index[7:0],
    // active_source[2:0], general_led, part_led, zero fill
    output logic [31:0] m_axis_tdata,
    input  logic        cfg_wen,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_wdata
);

    logic [7:0] debounce_limit_reg;
    logic [7:0] general_max_reg;
    logic [7:0] part_max_reg;
    logic [7:0] step_max_reg;

    logic    in_valid_reg;
    sample_t in_reg;
    logic    out_valid_reg;
    result_t out_reg;

    logic       general_mode_reg, general_mode_next;
    logic       part_mode_reg, part_mode_next;
    logic [NUM_BUTTONS-1:0] raw_prev_reg, raw_prev_next;
    logic [NUM_BUTTONS-1:0] stable_reg, stable_next;
    logic [7:0] timer_reg [NUM_BUTTONS];
    logic [7:0] timer_next [NUM_BUTTONS];
    logic [NUM_BUTTONS-1:0] clk_prev_reg, clk_prev_next;
    logic [7:0] general_index_reg, general_index_next;
    logic [7:0] part_index_reg, part_index_next;
    logic [7:0] step_index_reg, step_index_next;
    logic       direction_reg, direction_next;
    source_t    source_reg, source_next;
    result_t    out_next;

    logic                   advance;
    logic [NUM_BUTTONS-1:0] raw;
    logic [NUM_BUTTONS-1:0] changed;
    logic [NUM_BUTTONS-1:0] released;
    logic [NUM_BUTTONS-1:0] clk_now;
    logic [NUM_BUTTONS-1:0] edge_seen;

    assign advance       = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = !in_valid_reg || advance;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {2'b00, out_reg};

    assign raw     = {in_reg.data_button, in_reg.part_button, in_reg.general_button};
    assign clk_now = {in_reg.data_clk, in_reg.part_clk, in_reg.general_clk};

    always_comb begin
        raw_prev_next = raw;
        stable_next   = stable_reg;
        changed       = '0;
        released      = '0;
        for (int b = 0; b < NUM_BUTTONS; b++) begin
            if (raw[b] != raw_prev_reg[b]) begin
                timer_next[b] = 8'd0;
            end else if (in_reg.ms_tick && timer_reg[b] != TIMER_MAX) begin
                timer_next[b] = timer_reg[b] + 8'd1;
            end else begin
                timer_next[b] = timer_reg[b];
            end
            if (timer_next[b] > debounce_limit_reg && raw[b] != stable_reg[b]) begin
                stable_next[b] = raw[b];
                changed[b]     = 1'b1;
                released[b]    = raw[b];
            end
        end

        edge_seen     = clk_now ^ clk_prev_reg;
        clk_prev_next = clk_now;

        general_mode_next  = general_mode_reg ^ released[BTN_GENERAL];
        part_mode_next     = part_mode_reg ^ released[BTN_PART];
        source_next        = source_reg;
        direction_next     = direction_reg;
        general_index_next = general_index_reg;
        part_index_next    = part_index_reg;
        step_index_next    = step_index_reg;

        if (changed[BTN_GENERAL]) begin
            source_next = general_mode_next ? SRC_GENERAL : SRC_PATTERN;
        end
        if (changed[BTN_PART]) begin
            source_next = part_mode_next ? SRC_PART : SRC_STEP;
        end

        if (general_mode_next) begin
            if (edge_seen[BTN_GENERAL]) source_next = SRC_GENERAL;
            general_index_next = step_clamp(general_index_reg, in_reg.general_clk,
                                            in_reg.general_dt, edge_seen[BTN_GENERAL],
                                            general_max_reg);
        end else if (edge_seen[BTN_GENERAL]) begin
            source_next    = SRC_PATTERN;
            direction_next = (in_reg.general_dt == in_reg.general_clk);
        end

        if (part_mode_next) begin
            if (edge_seen[BTN_PART]) source_next = SRC_PART;
            part_index_next = step_clamp(part_index_reg, in_reg.part_clk, in_reg.part_dt,
                                         edge_seen[BTN_PART], part_max_reg);
        end else begin
            if (edge_seen[BTN_PART]) source_next = SRC_STEP;
            step_index_next = step_clamp(step_index_reg, in_reg.part_clk, in_reg.part_dt,
                                         edge_seen[BTN_PART], step_max_reg);
        end

        if (edge_seen[BTN_DATA]) source_next = SRC_DATA;

        out_next.parameter_index = general_index_next;
        out_next.turn_direction  = direction_next;
        out_next.part_index      = part_index_next;
        out_next.step_index      = step_index_next;
        out_next.active_source   = source_next;
        out_next.general_led     = !general_mode_next;
        out_next.part_led        = !part_mode_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            debounce_limit_reg <= DEBOUNCE_LIMIT_RST;
            general_max_reg    <= GENERAL_MAX_RST;
            part_max_reg       <= PART_MAX_RST;
            step_max_reg       <= STEP_MAX_RST;
        end else if (cfg_wen) begin
            unique case (cfg_index)
                REG_DEBOUNCE_LIMIT: debounce_limit_reg <= cfg_wdata;
                REG_GENERAL_MAX:    general_max_reg    <= cfg_wdata;
                REG_PART_MAX:       part_max_reg       <= cfg_wdata;
                REG_STEP_MAX:       step_max_reg       <= cfg_wdata;
                default:            ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (s_axis_tready) begin
            in_reg <= sample_t'(s_axis_tdata[9:0]);
        end
        if (advance && in_valid_reg) begin
            out_reg <= out_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg      <= 1'b0;
            out_valid_reg     <= 1'b0;
            general_mode_reg  <= 1'b1;
            part_mode_reg     <= 1'b1;
            raw_prev_reg      <= '1;
            stable_reg        <= '1;
            clk_prev_reg      <= '0;
            general_index_reg <= 8'd0;
            part_index_reg    <= 8'd0;
            step_index_reg    <= 8'd0;
            direction_reg     <= 1'b0;
            source_reg        <= SRC_GENERAL;
            for (int b = 0; b < NUM_BUTTONS; b++) begin
                timer_reg[b] <= 8'd0;
            end
        end else begin
            if (s_axis_tready) begin
                in_valid_reg <= s_axis_tvalid;
            end
            if (advance) begin
                out_valid_reg <= in_valid_reg;
            end
            if (advance && in_valid_reg) begin
                general_mode_reg  <= general_mode_next;
                part_mode_reg     <= part_mode_next;
                raw_prev_reg      <= raw_prev_next;
                stable_reg        <= stable_next;
                clk_prev_reg      <= clk_prev_next;
                general_index_reg <= general_index_next;
                part_index_reg    <= part_index_next;
                step_index_reg    <= step_index_next;
                direction_reg     <= direction_next;
                source_reg        <= source_next;
                for (int b = 0; b < NUM_BUTTONS; b++) begin
                    timer_reg[b] <= timer_next[b];
                end
            end
        end
    end

endmodule
